/* hw/rtl/kps_pkg.sv */
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants of the two-bank knob panel with soft takeover.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

	localparam int ADC_BITS_DEF = 12;  // converter sample width
	localparam int SCAN_W       = 16;  // scan period and tick counter width
	localparam int WIN_W        = 12;  // pickup window width
	localparam int CFG_AW       = 1;   // register index width
	localparam int CFG_DW       = 16;  // widest register
	localparam int NUM_KNOBS    = 4;
	localparam int GATED_KNOB   = 2;   // bank A knob three feeds the noise gate

	typedef enum logic [CFG_AW-1:0] {
		REG_SCAN_PERIOD   = 1'b0,
		REG_PICKUP_WINDOW = 1'b1
	} cfg_reg_t;

	// Control and status from the scan core to the top level.
	typedef struct packed {
		logic                 is_scan;  // this tick scans the panel
		logic                 bank;     // bank picked by the switch
		logic [NUM_KNOBS-1:0] caught;   // pickup flags after this tick
	} scan_status_t;

endpackage

`default_nettype wire

/* hw/rtl/knob_soft_takeover_two_bank.sv */
// ----------------------------------------------------------------------------
// knob_soft_takeover_two_bank
// Two-bank knob panel with soft takeover: every scan_period ticks the bank
// switch and four knobs are scanned, stored values follow knobs once caught,
// and bank A knob three drives a noise-gated delay value.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: switch, knobs one to four
//  m_*      | out | m_tvalid/m_tready  | m_tdata: mask + 8 values, m_tuser: bank
//  cfg_*    | in  | cfg_we             | cfg_addr: register, cfg_wdata: value
//
// One tick is accepted per cycle unless the input register stalls. A tick is
// held in the input register while the scan core decides pickup from it,
// and a scanning tick that advances is loaded into the output register,
// which offers its result on the m_* channel.
// Ticks that do not scan produce no transfer. A scanning tick waits in the
// input register only while the output register holds an untaken result.
// Reset clears the counter, bank, flags and all stored values; the first tick
// after reset scans.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_soft_takeover_two_bank import kps_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// switch_sample, knob_one, knob_two, knob_three, knob_four; zero padded
	input  wire logic [((5*ADC_BITS+7)/8)*8-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// caught_mask, tempo, scale, delay, feedback, envelope, phaser_rate,
	// phaser_feedback, volume; zero padded
	output logic [((4+8*ADC_BITS+7)/8)*8-1:0] m_tdata,
	// bank_select
	output logic                     m_tuser,
	input  wire logic                cfg_we,
	input  wire logic [CFG_AW-1:0]   cfg_addr,
	input  wire logic [CFG_DW-1:0]   cfg_wdata
);

	localparam int IN_W  = ((5*ADC_BITS+7)/8)*8;
	localparam int OUT_W = ((4+8*ADC_BITS+7)/8)*8;
	localparam int VAL_W = 4 + 8*ADC_BITS;

	// Configuration registers
	logic [SCAN_W-1:0] scan_period_q;
	logic [WIN_W-1:0]  pickup_window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q   <= SCAN_W'(1);
			pickup_window_q <= WIN_W'(32);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_SCAN_PERIOD:   scan_period_q   <= cfg_wdata[SCAN_W-1:0];
				REG_PICKUP_WINDOW: pickup_window_q <= cfg_wdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic            valid_s1;
	logic [IN_W-1:0] data_s1;
	logic            advance;
	scan_status_t    status;

	// Take the held tick unless it scans and the output slot holds an untaken result.
	assign advance = valid_s1 && (!status.is_scan || !m_tvalid || m_tready);

	kps_in_stage #(
		.W(IN_W)
	) u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// Unpack the tick
	logic [ADC_BITS-1:0] switch_sample;
	logic [ADC_BITS-1:0] knob [NUM_KNOBS];

	assign switch_sample = data_s1[ADC_BITS-1:0];
	for (genvar k = 0; k < NUM_KNOBS; k++) begin : g_unpack
		assign knob[k] = data_s1[(k+1)*ADC_BITS +: ADC_BITS];
	end

	// Scan core
	logic [ADC_BITS-1:0] bank_a_next [NUM_KNOBS];
	logic [ADC_BITS-1:0] bank_b_next [NUM_KNOBS];
	logic [ADC_BITS-1:0] gated_next;

	kps_scan_core #(
		.ADC_BITS(ADC_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (advance),
		.switch_sample (switch_sample),
		.knob          (knob),
		.scan_period   (scan_period_q),
		.pickup_window (pickup_window_q),
		.status        (status),
		.bank_a_next   (bank_a_next),
		.bank_b_next   (bank_b_next),
		.gated_next    (gated_next)
	);

	// Output register: bank A knob three is replaced by the gated delay value.
	logic [VAL_W-1:0] result;
	logic             load_out;

	assign result = {bank_b_next[3], bank_b_next[2], bank_b_next[1], bank_b_next[0],
		bank_a_next[3], gated_next, bank_a_next[1], bank_a_next[0], status.caught};
	assign load_out = advance && status.is_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= OUT_W'(result);
			m_tuser <= status.bank;
		end
	end

`ifndef SYNTHESIS
	// Never overwrite a result that is still waiting for its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(load_out && m_tvalid && !m_tready))
		else $error("output result overwritten while stalled");

	// A scanning tick that advances shows up at the output next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("scan result not presented");

	// Input side stalls only while a tick is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

/* hw/rtl/kps_in_stage.sv */
// ----------------------------------------------------------------------------
// kps_in_stage
// Input register: captures one tick from the slave stream and holds it until
// the scan core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_in_stage import kps_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [W-1:0] s_tdata,
	input  wire logic         advance,   // core takes the held tick this cycle
	output logic              valid_s1,
	output logic [W-1:0]      data_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/kps_scan_core.sv */
// ----------------------------------------------------------------------------
// kps_scan_core
// Panel state (tick counter, bank, pickup flags, stored knob values, gated
// delay) and the combinational pickup decision for the held tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_scan_core import kps_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,            // commit this tick
	input  wire logic [ADC_BITS-1:0] switch_sample,
	input  wire logic [ADC_BITS-1:0] knob [NUM_KNOBS],
	input  wire logic [SCAN_W-1:0]   scan_period,
	input  wire logic [WIN_W-1:0]    pickup_window,
	output scan_status_t             status,
	output logic [ADC_BITS-1:0]      bank_a_next [NUM_KNOBS],
	output logic [ADC_BITS-1:0]      bank_b_next [NUM_KNOBS],
	output logic [ADC_BITS-1:0]      gated_next
);

	localparam int CMP_W = (ADC_BITS > WIN_W) ? ADC_BITS : WIN_W;

	logic [SCAN_W-1:0]    tick_q;
	logic                 last_bank_q;
	logic [NUM_KNOBS-1:0] flags_q;
	logic [ADC_BITS-1:0]  bank_a_q [NUM_KNOBS];
	logic [ADC_BITS-1:0]  bank_b_q [NUM_KNOBS];
	logic [ADC_BITS-1:0]  gated_q;

	logic                 bank;
	logic [NUM_KNOBS-1:0] flag_base;
	logic [NUM_KNOBS-1:0] caught;
	logic [ADC_BITS-1:0]  gate_dist;
	logic                 gate_move;

	// Switch at or above half scale selects bank B.
	assign bank      = switch_sample[ADC_BITS-1];
	assign flag_base = (bank != last_bank_q) ? '0 : flags_q;

	for (genvar k = 0; k < NUM_KNOBS; k++) begin : g_knob
		logic [ADC_BITS-1:0] held;
		logic [ADC_BITS-1:0] knob_dist;

		assign held = bank ? bank_b_q[k] : bank_a_q[k];
		assign knob_dist = (knob[k] >= held) ? (knob[k] - held) : (held - knob[k]);
		assign caught[k] = flag_base[k] ||
			(CMP_W'(knob_dist) <= CMP_W'(pickup_window));

		assign bank_a_next[k] = (!bank && caught[k]) ? knob[k] : bank_a_q[k];
		assign bank_b_next[k] = ( bank && caught[k]) ? knob[k] : bank_b_q[k];
	end

	assign gate_dist = (knob[GATED_KNOB] >= gated_q) ?
		(knob[GATED_KNOB] - gated_q) : (gated_q - knob[GATED_KNOB]);
	assign gate_move = !bank && caught[GATED_KNOB] &&
		(CMP_W'(gate_dist) > CMP_W'(pickup_window));
	assign gated_next = gate_move ? knob[GATED_KNOB] : gated_q;

	assign status.is_scan = (tick_q <= SCAN_W'(1));
	assign status.bank    = bank;
	assign status.caught  = caught;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			last_bank_q <= 1'b0;
			flags_q     <= '0;
			gated_q     <= '0;
			for (int k = 0; k < NUM_KNOBS; k++) begin
				bank_a_q[k] <= '0;
				bank_b_q[k] <= '0;
			end
		end else if (go) begin
			if (status.is_scan) begin
				tick_q      <= scan_period;
				last_bank_q <= bank;
				flags_q     <= caught;
				gated_q     <= gated_next;
				for (int k = 0; k < NUM_KNOBS; k++) begin
					bank_a_q[k] <= bank_a_next[k];
					bank_b_q[k] <= bank_b_next[k];
				end
			end else begin
				tick_q <= tick_q - SCAN_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* tb/knob_soft_takeover_two_bank_tb.sv */
// ----------------------------------------------------------------------------
// knob_soft_takeover_two_bank_tb
// Self-checking bench for the two-bank knob panel. A queue of ticks feeds a
// bursty stream driver; every accepted tick advances a local copy of the
// panel. A stalling sink checks each scan result, field by field, against the
// oldest prediction. Phases walk scan period and pickup window through their
// extremes, with knob motion that sweeps through stored values so pickup, bank
// changes and the delay noise gate are all exercised.
// ----------------------------------------------------------------------------
module knob_soft_takeover_two_bank_tb;
	import kps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AB        = ADC_BITS_DEF;
	localparam int S_W       = ((5*AB+7)/8)*8;
	localparam int M_W       = ((4+8*AB+7)/8)*8;
	localparam int FULL      = (1 << AB) - 1;
	localparam int HALF      = 1 << (AB-1);
	localparam int QUIET_MAX = 2000;  // cycles without any transfer before giving up

	// One tick as it travels in s_tdata: switch lowest, then knobs one to four.
	typedef struct packed {
		logic [NUM_KNOBS-1:0][AB-1:0] knob;
		logic [AB-1:0]                sw;
	} tick_t;

	// One scan result. value[0..3] tempo, scale, delay (gated), feedback;
	// value[4..7] envelope, phaser rate, phaser feedback, volume.
	typedef struct packed {
		logic                 bank;
		logic [NUM_KNOBS-1:0] caught;
		logic [7:0][AB-1:0]   value;
	} scan_t;

	typedef enum int {SINK_READY, SINK_COIN, SINK_ONE_IN_FOUR, SINK_MOSTLY} sink_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [S_W-1:0]    s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [M_W-1:0]    m_tdata;
	logic              m_tuser;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = REG_SCAN_PERIOD;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	knob_soft_takeover_two_bank u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Panel shadow: registers as last written, plus the state they act on.
	logic [SCAN_W-1:0] period_q = 16'd1;
	logic [WIN_W-1:0]  window_q = 12'd32;
	logic [SCAN_W-1:0] ticks_left = '0;
	logic              panel_bank = 1'b0;
	logic [NUM_KNOBS-1:0] panel_caught = '0;
	logic [AB-1:0]     panel_store [8] = '{default: '0};
	logic [AB-1:0]     panel_gated = '0;

	tick_t pending_ticks [$];
	scan_t expected_scans [$];
	int    pushed_count = 0;
	int    accepted_count = 0;
	int    error_count = 0;

	// Mirror of the scan counter on the fill side, so a phase can stop on a scan.
	logic [SCAN_W-1:0] fill_left = '0;
	int hand [NUM_KNOBS] = '{default: 0};
	int switch_pos = 0;

	function automatic int knob_gap(input int a, input int b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic int clamp_sample(input int v);
		return (v < 0) ? 0 : (v > FULL) ? FULL : v;
	endfunction

	// Advance the panel by one accepted tick; a scanning tick queues a result.
	task automatic advance_panel(input tick_t t);
		logic  bank;
		int    slot;
		scan_t r;
		if (ticks_left > 1) begin
			ticks_left = ticks_left - 1'b1;
		end else begin
			ticks_left = period_q;
			bank = (int'(t.sw) >= HALF);
			if (bank != panel_bank) begin
				panel_caught = '0;
			end
			panel_bank = bank;
			for (int k = 0; k < NUM_KNOBS; k++) begin
				slot = int'(bank) * NUM_KNOBS + k;
				if (panel_caught[k] ||
				    knob_gap(t.knob[k], panel_store[slot]) <= int'(window_q)) begin
					panel_caught[k] = 1'b1;
					panel_store[slot] = t.knob[k];
					// Noise gate: delay follows only on a step wider than the window.
					if (slot == GATED_KNOB &&
					    knob_gap(t.knob[k], panel_gated) > int'(window_q)) begin
						panel_gated = t.knob[k];
					end
				end
			end
			r.bank = panel_bank;
			r.caught = panel_caught;
			for (int j = 0; j < 8; j++) begin
				r.value[j] = panel_store[j];
			end
			r.value[GATED_KNOB] = panel_gated;
			expected_scans.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ERROR %s: got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Stream driver: bursts of random length, random gaps, holds data while
	// the block stalls. Prediction runs on every accepted transfer.
	// ------------------------------------------------------------------------
	tick_t cur_tick = '0;
	int    burst_left = 8;
	int    gap_left = 0;

	always @(posedge clk) begin : drive_proc
		logic  nv;
		tick_t nxt;
		nv = s_tvalid;
		nxt = cur_tick;
		if (s_tvalid && s_tready) begin
			advance_panel(cur_tick);
			accepted_count++;
			nv = 1'b0;
		end
		if (!nv) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_ticks.size() > 0) begin
				nxt = pending_ticks.pop_front();
				nv = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					// New burst; a third of bursts run straight into the next.
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		cur_tick = nxt;
		s_tvalid <= nv;
		s_tdata <= {{(S_W-$bits(tick_t)){1'b0}}, nxt};
	end

	// ------------------------------------------------------------------------
	// Result sink: ready follows a randomly chosen pattern (always, coin toss,
	// one in four, mostly); every transfer is compared with the oldest prediction.
	// ------------------------------------------------------------------------
	sink_mode_t sink_mode = SINK_READY;
	int         sink_left = 0;
	int         sink_phase = 0;
	string      value_name [8] = '{"tempo_value", "scale_value", "delay_value",
		"feedback_value", "envelope_value", "phaser_rate_value",
		"phaser_feedback_value", "volume_value"};

	always @(posedge clk) begin : sink_proc
		logic               rdy;
		scan_t              want;
		logic [7:0][AB-1:0] got_value;
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(16, 96);
		end else begin
			sink_left--;
		end
		case (sink_mode)
			SINK_READY: begin
				rdy = 1'b1;
			end
			SINK_COIN: begin
				rdy = $urandom_range(0, 1);
			end
			SINK_ONE_IN_FOUR: begin
				rdy = (sink_phase % 4 == 0);
			end
			default: begin
				rdy = ($urandom_range(0, 3) != 0);
			end
		endcase
		sink_phase++;

		if (m_tvalid && m_tready) begin
			if (expected_scans.size() == 0) begin
				report_mismatch("scan result with none pending", 1, 0);
			end else begin
				want = expected_scans.pop_front();
				got_value = m_tdata[4 +: 8*AB];
				if (m_tuser !== want.bank) begin
					report_mismatch("bank_select", m_tuser, want.bank);
				end
				if (m_tdata[3:0] !== want.caught) begin
					report_mismatch("caught_mask", m_tdata[3:0], want.caught);
				end
				for (int j = 0; j < 8; j++) begin
					if (got_value[j] !== want.value[j]) begin
						report_mismatch(value_name[j], got_value[j], want.value[j]);
					end
				end
			end
		end
		m_tready <= rdy;
	end

	// Watchdog: give up after too long without a transfer on either side.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Write one register; only called while the panel is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCAN_PERIOD: begin
				period_q = val[SCAN_W-1:0];
			end
			REG_PICKUP_WINDOW: begin
				period_q = period_q;
				window_q = val[WIN_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Queue one tick, keeping the queue short so stored values stay fresh
	// for the snap mode; tell whether the tick will scan.
	task automatic push_tick(input tick_t t, output bit scans);
		while (pending_ticks.size() >= 4) begin
			@(posedge clk);
		end
		pending_ticks.push_back(t);
		pushed_count++;
		if (fill_left > 1) begin
			fill_left = fill_left - 1'b1;
			scans = 1'b0;
		end else begin
			fill_left = period_q;
			scans = 1'b1;
		end
	endtask

	function automatic tick_t mk_tick(input int sw, input int k1, input int k2,
	                                  input int k3, input int k4);
		tick_t t;
		t.sw = sw;
		t.knob[0] = k1;
		t.knob[1] = k2;
		t.knob[2] = k3;
		t.knob[3] = k4;
		return t;
	endfunction

	// Knob motion: mostly slow sweeps, some snaps onto the stored value of the
	// selected bank, a little pure noise; the switch flips now and then.
	task automatic make_tick(output tick_t t);
		int mode;
		int sp;
		int w;
		int bsel;
		mode = $urandom_range(0, 99);
		if ($urandom_range(0, 39) == 0) begin
			switch_pos = $urandom_range(0, 1) ? HALF : HALF - 1;
		end else if ($urandom_range(0, 11) == 0) begin
			switch_pos = $urandom_range(0, 1) ? $urandom_range(HALF, FULL)
			                                  : $urandom_range(0, HALF - 1);
		end
		bsel = (switch_pos >= HALF);
		w = int'(window_q);
		sp = (w + 8 > 1024) ? 1024 : w + 8;
		for (int k = 0; k < NUM_KNOBS; k++) begin
			if (mode < 10) begin
				hand[k] = $urandom_range(0, FULL);
			end else if (mode < 30) begin
				hand[k] = clamp_sample(int'(panel_store[bsel*NUM_KNOBS + k]) +
				                       int'($urandom_range(0, 2*w)) - w);
			end else begin
				hand[k] = clamp_sample(hand[k] + int'($urandom_range(0, 2*sp)) - sp);
			end
			t.knob[k] = hand[k];
		end
		t.sw = switch_pos;
	endtask

	// Hold until every queued tick is taken and every result has arrived,
	// then let the last non-scanning ticks leave the pipeline.
	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (accepted_count != pushed_count || expected_scans.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Configure, then feed random ticks until the given number of scans.
	task automatic run_phase(input logic [CFG_DW-1:0] period, input logic [CFG_DW-1:0] win,
	                         input int n_scans);
		tick_t t;
		bit    sc;
		int    seen;
		write_reg(REG_SCAN_PERIOD, period);
		write_reg(REG_PICKUP_WINDOW, win);
		seen = 0;
		while (seen < n_scans) begin
			make_tick(t);
			push_tick(t, sc);
			seen += sc;
		end
		wait_idle();
	endtask

	initial begin : stim_proc
		tick_t directed [$];
		tick_t t;
		bit    sc;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every tick scans, window of 32.
		directed.push_back(mk_tick(0, 0, 0, 0, 0));              // bank A, all caught at zero
		directed.push_back(mk_tick(HALF, 32, 33, FULL, 0));      // half scale is bank B; window edge
		directed.push_back(mk_tick(HALF - 1, FULL, FULL, FULL, FULL)); // back to A, none caught
		directed.push_back(mk_tick(0, 31, 0, 20, FULL));         // catch; gate holds on small step
		directed.push_back(mk_tick(1, 40, FULL, 100, 33));       // caught knobs follow; gate moves
		directed.push_back(mk_tick(HALF - 2, 0, 0, 132, 32));    // gate step equal to window holds
		directed.push_back(mk_tick(HALF, 32, FULL, FULL, FULL)); // bank B again, flags cleared
		directed.push_back(mk_tick(FULL, 0, FULL, FULL, 0));
		directed.push_back(mk_tick(FULL, FULL, 0, 0, FULL));
		directed.push_back(mk_tick(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
		directed.push_back(mk_tick(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
		directed.push_back(mk_tick(12'h555, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
		foreach (directed[i]) begin
			push_tick(directed[i], sc);
		end
		wait_idle();

		run_phase(16'd0, 16'd0, 40);          // zero period, exact-match pickup only
		run_phase(16'd3, 16'd4095, 25);       // widest window catches everything
		run_phase(16'd1, 16'd32, 50);
		run_phase(16'd2, 16'hF0C8, 40);       // upper data bits ignored: window 200
		run_phase(16'd7, 16'd15, 15);
		run_phase(16'd1, 16'd100, 40);

		// Longest period last: one scan loads it, the ticks after it stay silent.
		run_phase(16'hFFFF, 16'd64, 1);
		repeat (16) begin
			make_tick(t);
			push_tick(t, sc);
		end
		wait_idle();

		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* knob_soft_takeover_two_bank.f */
hw/rtl/kps_pkg.sv
hw/rtl/kps_in_stage.sv
hw/rtl/kps_scan_core.sv
hw/rtl/knob_soft_takeover_two_bank.sv
tb/knob_soft_takeover_two_bank_tb.sv
